@@ rtl/dns_message_parser_defines.svh @@
// ----------------------------------------------------------------------------
// DNS message parser assertion macros
// Shared property wrappers for the parser checks.
// ----------------------------------------------------------------------------
`ifndef DNS_MESSAGE_PARSER_DEFINES_SVH
`define DNS_MESSAGE_PARSER_DEFINES_SVH

// Same-cycle implication under synchronous reset
`define DNSP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication under synchronous reset
`define DNSP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/dnsp_pkg.sv @@
// ----------------------------------------------------------------------------
// dnsp_pkg
// Result record, stage control types and code constants of the DNS parser.
// ----------------------------------------------------------------------------
`default_nettype none

package dnsp_pkg;

   // Result kinds
   localparam logic [2:0] KIND_CHUNK  = 3'd0;
   localparam logic [2:0] KIND_RDATA  = 3'd1;
   localparam logic [2:0] KIND_QDONE  = 3'd2;
   localparam logic [2:0] KIND_RDONE  = 3'd3;
   localparam logic [2:0] KIND_OK     = 3'd4;
   localparam logic [2:0] KIND_ERROR  = 3'd5;

   // Error codes
   localparam logic [1:0] ERR_NAME_LONG = 2'd0;
   localparam logic [1:0] ERR_TRUNC     = 2'd1;
   localparam logic [1:0] ERR_POINTER   = 2'd2;

   // One result item
   typedef struct packed {
      logic [2:0]  kind;
      logic [1:0]  section;
      logic [63:0] name_chunk;
      logic [3:0]  chunk_len;
      logic [7:0]  out_byte;
      logic [15:0] rec_type;
      logic [15:0] rec_class;
      logic [31:0] time_to_live;
      logic [15:0] data_length;
      logic [1:0]  error_code;
   } res_type;

   // Sequencer requests to the result stage
   typedef struct packed {
      logic put;
      logic flush;
   } stage_ctl_type;

   // Result stage status back to the sequencer
   typedef struct packed {
      logic free;
      logic hold_valid;
   } stage_stat_type;

endpackage

`default_nettype wire

@@ rtl/dnsp_result_stage.sv @@
// ----------------------------------------------------------------------------
// dnsp_result_stage
// Holds the newest result one step back so run_end can mark the last result
// of a byte, and drives the registered result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module dnsp_result_stage (
   input  wire                     clock,
   input  wire                     reset,
   input  dnsp_pkg::stage_ctl_type ctl,
   input  dnsp_pkg::res_type       put_res,
   output dnsp_pkg::stage_stat_type stat,
   output logic                    rsp_valid,
   input  wire                     rsp_stall,
   output dnsp_pkg::res_type       rsp_res,
   output logic                    rsp_run_end
);
   import dnsp_pkg::*;

   logic    out_valid_ff, out_valid_in;
   logic    hold_valid_ff, hold_valid_in;
   res_type hold_ff, hold_in;
   res_type out_ff, out_in;
   logic    out_end_ff, out_end_in;
   logic    taken;

   assign taken = out_valid_ff && !rsp_stall;

   // Advance held result into the output register on put or flush
   always_comb begin
      out_valid_in  = out_valid_ff && !taken;
      hold_valid_in = hold_valid_ff;
      hold_in       = hold_ff;
      out_in        = out_ff;
      out_end_in    = out_end_ff;
      if (ctl.put) begin
         if (hold_valid_ff) begin
            out_in       = hold_ff;
            out_end_in   = 1'b0;
            out_valid_in = 1'b1;
         end
         hold_in       = put_res;
         hold_valid_in = 1'b1;
      end else if (ctl.flush && hold_valid_ff) begin
         out_in        = hold_ff;
         out_end_in    = 1'b1;
         out_valid_in  = 1'b1;
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         hold_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         hold_valid_ff <= hold_valid_in;
      end
      hold_ff    <= hold_in;
      out_ff     <= out_in;
      out_end_ff <= out_end_in;
   end

   assign stat.free       = !out_valid_ff || !rsp_stall;
   assign stat.hold_valid = hold_valid_ff;
   assign rsp_valid       = out_valid_ff;
   assign rsp_res         = out_ff;
   assign rsp_run_end     = out_end_ff;

endmodule

`default_nettype wire

@@ rtl/dns_message_parser.sv @@
// ----------------------------------------------------------------------------
// dns_message_parser
// DNS message parser with name compression, one message byte per transfer.
// ----------------------------------------------------------------------------
// Takes one message byte per transfer and works on it alone: req_stall is
// high from the transfer until every result of that byte is in the result
// stage. A finished name is read out one character at a time through the
// single name memory read port, in chunks of up to 8 characters. A
// compression pointer walks the packet memory through its single read
// port: it reads both pointer bytes, then each label code, copies each
// character with one read and one name write, and adds a dot per label.
// Result stalls delay the work on a byte.
// No clearing pass follows reset.
`default_nettype none
`include "dns_message_parser_defines.svh"

module dns_message_parser #(
   parameter int BUFFER_DEPTH = 512,
   parameter int NAME_MAX     = 256,
   parameter int RDATA_MAX    = 16
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [7:0]  req_data_byte,
   input  wire         req_last_byte,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [2:0]  rsp_kind,
   output logic [1:0]  rsp_section,
   output logic [63:0] rsp_name_chunk,
   output logic [3:0]  rsp_chunk_len,
   output logic [7:0]  rsp_out_byte,
   output logic [15:0] rsp_rec_type,
   output logic [15:0] rsp_rec_class,
   output logic [31:0] rsp_time_to_live,
   output logic [15:0] rsp_data_length,
   output logic [1:0]  rsp_error_code,
   output logic        rsp_run_end
);
   import dnsp_pkg::*;

   localparam int AW = $clog2(BUFFER_DEPTH);
   localparam logic [16:0] DEPTH_W     = 17'(BUFFER_DEPTH);
   localparam logic [9:0]  NAME_MAX_W  = 10'(NAME_MAX);
   localparam logic [16:0] RDATA_MAX_W = 17'(RDATA_MAX);

   // Parse phases
   localparam logic [3:0] PH_HDR   = 4'd0;
   localparam logic [3:0] PH_LEN   = 4'd1;
   localparam logic [3:0] PH_LABEL = 4'd2;
   localparam logic [3:0] PH_PTR   = 4'd3;
   localparam logic [3:0] PH_FIX   = 4'd4;
   localparam logic [3:0] PH_RDATA = 4'd5;
   localparam logic [3:0] PH_IDLE  = 4'd6;

   // Sequencer states
   localparam logic [4:0] SQ_IDLE    = 5'd0;
   localparam logic [4:0] SQ_EXEC    = 5'd1;
   localparam logic [4:0] SQ_OPEN    = 5'd2;
   localparam logic [4:0] SQ_FAIL    = 5'd3;
   localparam logic [4:0] SQ_END     = 5'd4;
   localparam logic [4:0] SQ_FLUSH   = 5'd5;
   localparam logic [4:0] SQ_FIXEND  = 5'd6;
   localparam logic [4:0] SQ_RDPUT   = 5'd7;
   localparam logic [4:0] SQ_RECDONE = 5'd8;
   localparam logic [4:0] SQ_ADV     = 5'd9;
   localparam logic [4:0] SQ_DOT     = 5'd10;
   localparam logic [4:0] SQ_NDONE   = 5'd11;
   localparam logic [4:0] SQ_CRD     = 5'd12;
   localparam logic [4:0] SQ_CGET    = 5'd13;
   localparam logic [4:0] SQ_CPUT    = 5'd14;
   localparam logic [4:0] SQ_WALK    = 5'd15;
   localparam logic [4:0] SQ_WB      = 5'd16;
   localparam logic [4:0] SQ_WP2     = 5'd17;
   localparam logic [4:0] SQ_WCRD    = 5'd18;
   localparam logic [4:0] SQ_WCWR    = 5'd19;
   localparam logic [4:0] SQ_WDOT    = 5'd20;

   localparam logic [7:0] DOT_CHAR = 8'h2E;
   localparam logic [3:0] MAX_JUMPS = 4'd10;

   // Memories
   logic [7:0] pkt_mem [BUFFER_DEPTH];
   logic [7:0] name_mem [256];
   logic          pk_we, pk_re;
   logic [AW-1:0] pk_waddr, pk_raddr;
   logic [7:0]    pk_rdata_ff;
   logic          nm_we, nm_re;
   logic [7:0]    nm_waddr, nm_raddr, nm_wdata;
   logic [7:0]    nm_rdata_ff;

   // Control and datapath registers
   logic [4:0]  seq_ff, seq_in;
   logic [3:0]  phase_ff, phase_in;
   logic [15:0] bpos_ff, bpos_in;
   logic [7:0]  byte_ff, byte_in;
   logic        last_ff, last_in;
   logic [15:0] pos_ff, pos_in;
   logic [15:0] cnt_ff [4];
   logic [15:0] cnt_in [4];
   logic [15:0] entries_ff, entries_in;
   logic [1:0]  sect_ff, sect_in;
   logic [8:0]  nlen_ff, nlen_in;
   logic [7:0]  lrem_ff, lrem_in;
   logic [63:0] fshift_ff, fshift_in;
   logic [15:0] rdrem_ff, rdrem_in;
   logic [15:0] held_ff, held_in;
   logic [1:0]  done_ff, done_in;
   logic [2:0]  ostart_ff, ostart_in;
   logic [1:0]  fcode_ff, fcode_in;
   logic [16:0] wp_ff, wp_in;
   logic [3:0]  jumps_ff, jumps_in;
   logic [5:0]  whi_ff, whi_in;
   logic [7:0]  wlen_ff, wlen_in;
   logic [7:0]  wk_ff, wk_in;
   logic [7:0]  nend_ff, nend_in;
   logic [7:0]  cidx_ff, cidx_in;
   logic [3:0]  ck_ff, ck_in;
   logic [63:0] acc_ff, acc_in;

   logic           accept;
   logic [16:0]    avail;
   logic           open_found;
   logic [1:0]     open_sel;
   stage_ctl_type  st_ctl;
   stage_stat_type st_stat;
   res_type        put_res;
   res_type        out_res;
   logic [1:0]     hdr_idx;
   logic [15:0]    hdr_off;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (seq_ff != SQ_IDLE);
   assign avail     = ({1'b0, bpos_ff} < DEPTH_W) ? {1'b0, bpos_ff} : DEPTH_W;
   assign hdr_off   = pos_ff - 16'd4;
   assign hdr_idx   = hdr_off[2:1];

   // Find the first nonempty section at or after the start index
   always_comb begin
      open_found = 1'b0;
      open_sel   = 2'd0;
      for (int s = 0; s < 4; s++) begin
         if (!open_found && 3'(s) >= ostart_ff && cnt_ff[s] != 16'd0) begin
            open_found = 1'b1;
            open_sel   = 2'(s);
         end
      end
   end

   // Packet memory: write on transfer, registered read
   always_ff @(posedge clock) begin
      if (pk_we) pkt_mem[pk_waddr] <= byte_in;
      if (pk_re) pk_rdata_ff <= pkt_mem[pk_raddr];
   end

   // Name memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (nm_we) name_mem[nm_waddr] <= nm_wdata;
      if (nm_re) nm_rdata_ff <= name_mem[nm_raddr];
   end

   // Sequencer
   always_comb begin
      seq_in     = seq_ff;
      phase_in   = phase_ff;
      bpos_in    = bpos_ff;
      byte_in    = byte_ff;
      last_in    = last_ff;
      pos_in     = pos_ff;
      cnt_in     = cnt_ff;
      entries_in = entries_ff;
      sect_in    = sect_ff;
      nlen_in    = nlen_ff;
      lrem_in    = lrem_ff;
      fshift_in  = fshift_ff;
      rdrem_in   = rdrem_ff;
      held_in    = held_ff;
      done_in    = done_ff;
      ostart_in  = ostart_ff;
      fcode_in   = fcode_ff;
      wp_in      = wp_ff;
      jumps_in   = jumps_ff;
      whi_in     = whi_ff;
      wlen_in    = wlen_ff;
      wk_in      = wk_ff;
      nend_in    = nend_ff;
      cidx_in    = cidx_ff;
      ck_in      = ck_ff;
      acc_in     = acc_ff;

      pk_we    = 1'b0;
      pk_waddr = bpos_ff[AW-1:0];
      pk_re    = 1'b0;
      pk_raddr = wp_ff[AW-1:0];
      nm_we    = 1'b0;
      nm_waddr = nlen_ff[7:0];
      nm_wdata = byte_ff;
      nm_re    = 1'b0;
      nm_raddr = cidx_ff;

      st_ctl  = '0;
      put_res = '0;
      put_res.section = sect_ff;

      unique case (seq_ff)
         SQ_IDLE: begin
            if (accept) begin
               byte_in = req_data_byte;
               last_in = req_last_byte;
               pos_in  = bpos_ff;
               pk_we   = ({1'b0, bpos_ff} < DEPTH_W);
               if (bpos_ff != 16'hFFFF) bpos_in = bpos_ff + 16'd1;
               seq_in  = SQ_EXEC;
            end
         end

         SQ_EXEC: begin
            case (phase_ff)
               PH_HDR: begin
                  if (pos_ff >= 16'd4 && pos_ff <= 16'd11)
                     cnt_in[hdr_idx] = {cnt_ff[hdr_idx][7:0], byte_ff};
                  if (pos_ff >= 16'd11) begin
                     ostart_in = 3'd0;
                     seq_in    = SQ_OPEN;
                  end else begin
                     seq_in = SQ_END;
                  end
               end
               PH_LEN: begin
                  if (byte_ff == 8'd0) begin
                     seq_in = SQ_NDONE;
                  end else if (byte_ff[7:6] == 2'b11) begin
                     lrem_in  = {2'b00, byte_ff[5:0]};
                     phase_in = PH_PTR;
                     seq_in   = SQ_END;
                  end else if ({1'b0, nlen_ff} + {2'b00, byte_ff} + 10'd1 >= NAME_MAX_W) begin
                     fcode_in = ERR_NAME_LONG;
                     seq_in   = SQ_FAIL;
                  end else begin
                     lrem_in  = byte_ff;
                     phase_in = PH_LABEL;
                     seq_in   = SQ_END;
                  end
               end
               PH_LABEL: begin
                  nm_we   = 1'b1;
                  nlen_in = nlen_ff + 9'd1;
                  lrem_in = lrem_ff - 8'd1;
                  seq_in  = (lrem_ff == 8'd1) ? SQ_DOT : SQ_END;
               end
               PH_PTR: begin
                  wp_in    = {3'b000, lrem_ff[5:0], byte_ff};
                  jumps_in = 4'd1;
                  seq_in   = SQ_WALK;
               end
               PH_FIX: begin
                  if (sect_ff != 2'd0 && lrem_ff <= 8'd2)
                     held_in = {held_ff[7:0], byte_ff};
                  else
                     fshift_in = {fshift_ff[55:0], byte_ff};
                  lrem_in = lrem_ff - 8'd1;
                  seq_in  = (lrem_ff == 8'd1) ? SQ_FIXEND : SQ_END;
               end
               PH_RDATA: seq_in = SQ_RDPUT;
               default:  seq_in = SQ_END;
            endcase
         end

         SQ_DOT: begin
            nm_we    = 1'b1;
            nm_wdata = DOT_CHAR;
            nlen_in  = nlen_ff + 9'd1;
            phase_in = PH_LEN;
            seq_in   = SQ_END;
         end

         SQ_FIXEND: begin
            if (sect_ff == 2'd0) begin
               if (st_stat.free) begin
                  st_ctl.put        = 1'b1;
                  put_res.kind      = KIND_QDONE;
                  put_res.rec_type  = fshift_ff[31:16];
                  put_res.rec_class = fshift_ff[15:0];
                  seq_in            = SQ_ADV;
               end
            end else if (held_ff == 16'd0) begin
               seq_in = SQ_RECDONE;
            end else begin
               rdrem_in = held_ff;
               phase_in = PH_RDATA;
               seq_in   = SQ_END;
            end
         end

         SQ_RDPUT: begin
            if ({1'b0, held_ff} > RDATA_MAX_W || st_stat.free) begin
               if ({1'b0, held_ff} <= RDATA_MAX_W) begin
                  st_ctl.put       = 1'b1;
                  put_res.kind     = KIND_RDATA;
                  put_res.out_byte = byte_ff;
               end
               rdrem_in = rdrem_ff - 16'd1;
               seq_in   = (rdrem_ff == 16'd1) ? SQ_RECDONE : SQ_END;
            end
         end

         SQ_RECDONE: begin
            if (st_stat.free) begin
               st_ctl.put           = 1'b1;
               put_res.kind         = KIND_RDONE;
               put_res.rec_type     = fshift_ff[63:48];
               put_res.rec_class    = fshift_ff[47:32];
               put_res.time_to_live = fshift_ff[31:0];
               put_res.data_length  = held_ff;
               seq_in               = SQ_ADV;
            end
         end

         // Count down entries, move to the next section when empty
         SQ_ADV: begin
            entries_in = entries_ff - 16'd1;
            if (entries_ff == 16'd1) begin
               ostart_in = {1'b0, sect_ff} + 3'd1;
               seq_in    = SQ_OPEN;
            end else begin
               nlen_in  = 9'd0;
               phase_in = PH_LEN;
               seq_in   = SQ_END;
            end
         end

         SQ_OPEN: begin
            if (open_found) begin
               sect_in    = open_sel;
               entries_in = cnt_ff[open_sel];
               nlen_in    = 9'd0;
               phase_in   = PH_LEN;
               seq_in     = SQ_END;
            end else if (st_stat.free) begin
               st_ctl.put   = 1'b1;
               put_res.kind = KIND_OK;
               done_in      = 2'd1;
               phase_in     = PH_IDLE;
               seq_in       = SQ_END;
            end
         end

         SQ_FAIL: begin
            if (st_stat.free) begin
               st_ctl.put         = 1'b1;
               put_res.kind       = KIND_ERROR;
               put_res.error_code = fcode_ff;
               done_in            = 2'd2;
               phase_in           = PH_IDLE;
               seq_in             = SQ_END;
            end
         end

         // Name finished: set up chunk readout, or go on to the fixed fields when no characters remain
         SQ_NDONE: begin
            nend_in = (nlen_ff != 9'd0) ? 8'(nlen_ff - 9'd1) : 8'd0;
            cidx_in = 8'd0;
            ck_in   = 4'd0;
            acc_in  = 64'd0;
            if (nlen_ff <= 9'd1) begin
               nlen_in   = 9'd0;
               fshift_in = 64'd0;
               held_in   = 16'd0;
               lrem_in   = (sect_ff == 2'd0) ? 8'd4 : 8'd10;
               phase_in  = PH_FIX;
               seq_in    = SQ_END;
            end else begin
               seq_in = SQ_CRD;
            end
         end

         SQ_CRD: begin
            nm_re  = 1'b1;
            seq_in = SQ_CGET;
         end

         SQ_CGET: begin
            acc_in  = acc_ff | (64'(nm_rdata_ff) << {ck_ff[2:0], 3'b000});
            ck_in   = ck_ff + 4'd1;
            cidx_in = cidx_ff + 8'd1;
            seq_in  = (ck_ff == 4'd7 || cidx_ff + 8'd1 == nend_ff) ? SQ_CPUT : SQ_CRD;
         end

         SQ_CPUT: begin
            if (st_stat.free) begin
               st_ctl.put         = 1'b1;
               put_res.kind       = KIND_CHUNK;
               put_res.name_chunk = acc_ff;
               put_res.chunk_len  = ck_ff;
               acc_in             = 64'd0;
               ck_in              = 4'd0;
               if (cidx_ff < nend_ff) begin
                  seq_in = SQ_CRD;
               end else begin
                  nlen_in   = 9'd0;
                  fshift_in = 64'd0;
                  held_in   = 16'd0;
                  lrem_in   = (sect_ff == 2'd0) ? 8'd4 : 8'd10;
                  phase_in  = PH_FIX;
                  seq_in    = SQ_END;
               end
            end
         end

         // Pointer walk over received bytes
         SQ_WALK: begin
            if (jumps_ff >= MAX_JUMPS) begin
               seq_in = SQ_NDONE;
            end else if (wp_ff >= avail) begin
               fcode_in = ERR_POINTER;
               seq_in   = SQ_FAIL;
            end else begin
               pk_re  = 1'b1;
               seq_in = SQ_WB;
            end
         end

         SQ_WB: begin
            if (pk_rdata_ff == 8'd0) begin
               seq_in = SQ_NDONE;
            end else if (pk_rdata_ff[7:6] == 2'b11) begin
               if (wp_ff + 17'd1 >= avail) begin
                  fcode_in = ERR_POINTER;
                  seq_in   = SQ_FAIL;
               end else begin
                  pk_re    = 1'b1;
                  pk_raddr = AW'(wp_ff + 17'd1);
                  whi_in   = pk_rdata_ff[5:0];
                  seq_in   = SQ_WP2;
               end
            end else if ({1'b0, nlen_ff} + {2'b00, pk_rdata_ff} + 10'd1 >= NAME_MAX_W) begin
               fcode_in = ERR_NAME_LONG;
               seq_in   = SQ_FAIL;
            end else if ({1'b0, wp_ff} + {10'd0, pk_rdata_ff} >= {1'b0, avail}) begin
               fcode_in = ERR_POINTER;
               seq_in   = SQ_FAIL;
            end else begin
               wlen_in = pk_rdata_ff;
               wk_in   = 8'd1;
               seq_in  = SQ_WCRD;
            end
         end

         SQ_WP2: begin
            wp_in    = {3'b000, whi_ff, pk_rdata_ff};
            jumps_in = jumps_ff + 4'd1;
            seq_in   = SQ_WALK;
         end

         SQ_WCRD: begin
            pk_re    = 1'b1;
            pk_raddr = AW'(wp_ff + {9'd0, wk_ff});
            seq_in   = SQ_WCWR;
         end

         SQ_WCWR: begin
            nm_we    = 1'b1;
            nm_wdata = pk_rdata_ff;
            nlen_in  = nlen_ff + 9'd1;
            if (wk_ff == wlen_ff) begin
               seq_in = SQ_WDOT;
            end else begin
               wk_in  = wk_ff + 8'd1;
               seq_in = SQ_WCRD;
            end
         end

         SQ_WDOT: begin
            nm_we    = 1'b1;
            nm_wdata = DOT_CHAR;
            nlen_in  = nlen_ff + 9'd1;
            wp_in    = wp_ff + {9'd0, wlen_ff} + 17'd1;
            seq_in   = SQ_WALK;
         end

         // Close the byte: early end check and re-arm on the final byte
         SQ_END: begin
            if (!last_ff) begin
               seq_in = SQ_FLUSH;
            end else if (done_ff != 2'd0 || st_stat.free) begin
               if (done_ff == 2'd0) begin
                  st_ctl.put         = 1'b1;
                  put_res.kind       = KIND_ERROR;
                  put_res.error_code = ERR_TRUNC;
               end
               bpos_in    = 16'd0;
               phase_in   = PH_HDR;
               for (int s = 0; s < 4; s++) cnt_in[s] = 16'd0;
               entries_in = 16'd0;
               sect_in    = 2'd0;
               nlen_in    = 9'd0;
               lrem_in    = 8'd0;
               fshift_in  = 64'd0;
               rdrem_in   = 16'd0;
               held_in    = 16'd0;
               done_in    = 2'd0;
               seq_in     = SQ_FLUSH;
            end
         end

         SQ_FLUSH: begin
            if (!st_stat.hold_valid) begin
               seq_in = SQ_IDLE;
            end else if (st_stat.free) begin
               st_ctl.flush = 1'b1;
               seq_in       = SQ_IDLE;
            end
         end

         default: seq_in = SQ_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff     <= SQ_IDLE;
         phase_ff   <= PH_HDR;
         bpos_ff    <= 16'd0;
         for (int s = 0; s < 4; s++) cnt_ff[s] <= 16'd0;
         entries_ff <= 16'd0;
         sect_ff    <= 2'd0;
         nlen_ff    <= 9'd0;
         lrem_ff    <= 8'd0;
         fshift_ff  <= 64'd0;
         rdrem_ff   <= 16'd0;
         held_ff    <= 16'd0;
         done_ff    <= 2'd0;
      end else begin
         seq_ff     <= seq_in;
         phase_ff   <= phase_in;
         bpos_ff    <= bpos_in;
         cnt_ff     <= cnt_in;
         entries_ff <= entries_in;
         sect_ff    <= sect_in;
         nlen_ff    <= nlen_in;
         lrem_ff    <= lrem_in;
         fshift_ff  <= fshift_in;
         rdrem_ff   <= rdrem_in;
         held_ff    <= held_in;
         done_ff    <= done_in;
      end
      byte_ff   <= byte_in;
      last_ff   <= last_in;
      pos_ff    <= pos_in;
      ostart_ff <= ostart_in;
      fcode_ff  <= fcode_in;
      wp_ff     <= wp_in;
      jumps_ff  <= jumps_in;
      whi_ff    <= whi_in;
      wlen_ff   <= wlen_in;
      wk_ff     <= wk_in;
      nend_ff   <= nend_in;
      cidx_ff   <= cidx_in;
      ck_ff     <= ck_in;
      acc_ff    <= acc_in;
   end

   dnsp_result_stage u_stage (
      .clock       (clock),
      .reset       (reset),
      .ctl         (st_ctl),
      .put_res     (put_res),
      .stat        (st_stat),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_res     (out_res),
      .rsp_run_end (rsp_run_end)
   );

   assign rsp_kind         = out_res.kind;
   assign rsp_section      = out_res.section;
   assign rsp_name_chunk   = out_res.name_chunk;
   assign rsp_chunk_len    = out_res.chunk_len;
   assign rsp_out_byte     = out_res.out_byte;
   assign rsp_rec_type     = out_res.rec_type;
   assign rsp_rec_class    = out_res.rec_class;
   assign rsp_time_to_live = out_res.time_to_live;
   assign rsp_data_length  = out_res.data_length;
   assign rsp_error_code   = out_res.error_code;

   // Checks
   `DNSP_ASSERT_NEXT(a_busy_after_transfer, clock, reset, accept, req_stall, "no stall after transfer")
   `DNSP_ASSERT_NOW(a_idle_hold_empty, clock, reset, seq_ff == SQ_IDLE, !st_stat.hold_valid, "result held while idle")
   `DNSP_ASSERT_NOW(a_chunk_len, clock, reset, rsp_valid && rsp_kind == KIND_CHUNK, rsp_chunk_len != 4'd0 && rsp_chunk_len <= 4'd8, "bad chunk length")
   `DNSP_ASSERT_NOW(a_put_free, clock, reset, st_ctl.put || st_ctl.flush, st_stat.free, "result issued into a full stage")

endmodule

`default_nettype wire
